FILE: rtl/prl_pkg.sv
// Shared types and constants for the prime range lister.
// Used by prl_rem and prime_range_lister; depends on nothing else.
`timescale 1ns / 1ps

package prl_pkg;

    // Width of each bound and of the reported prime on the ports
    localparam int unsigned FIELD_BITS = 8;

    // Smallest value that can be prime
    localparam int unsigned SMALLEST_PRIME = 2;

    // Status returned by the serial remainder unit
    typedef struct packed {
        logic done;   // one-cycle pulse: remainder is ready
        logic zero;   // remainder is zero (valid with done)
    } rem_res_t;

endpackage

FILE: rtl/prl_rem.sv
// Bit-serial remainder unit: restoring division, one dividend bit per cycle.
// Depends on prl_pkg for the result struct.
`timescale 1ns / 1ps

module prl_rem #(
    parameter int unsigned VALUE_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output prl_pkg::rem_res_t     res
);

    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic                  done_reg, done_next;
    logic                  zero_reg, zero_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic [VALUE_BITS-1:0] rem_step;

    // Shift in the next dividend bit and subtract the divisor if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_step = diff[VALUE_BITS-1:0];
        end
        else
        begin
            rem_step = trial[VALUE_BITS-1:0];
        end
    end

    // Sequence one division per start request
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (rem_step == '0);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        zero_reg <= zero_next;
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;

endmodule

FILE: rtl/prime_range_lister.sv
// Prime range lister: emits every prime strictly between two bounds, in order.
// Each divisor test runs in the serial remainder unit; a candidate c costs up to
// (c - 2) tests. One request is worked at a time; the next is taken once the
// last prime is handed to the output register. Reset (rst_n, async, low)
// returns to idle and drops any pending result.
// Depends on prl_pkg and prl_rem.
`timescale 1ns / 1ps

module prime_range_lister #(
    parameter int unsigned VALUE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] range_low, [15:8] range_high
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] prime_value
    output logic        m_axis_tlast    // last_flag
);

    localparam int unsigned FB = prl_pkg::FIELD_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FOUND = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS:0]   cand_reg, cand_next;
    logic [VALUE_BITS-1:0] hi_reg, hi_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [VALUE_BITS-1:0] pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic                  slot_free;
    logic                  rem_start;
    prl_pkg::rem_res_t     rem_res;

    prl_rem #(
        .VALUE_BITS(VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cand_reg[VALUE_BITS-1:0]),
        .divisor  (dvs_reg),
        .res      (rem_res)
    );

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // Walk candidates and divisors; hold one found prime until the next is known
    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        hi_next         = hi_reg;
        dvs_next        = dvs_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        rem_start       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cand_next       = {1'b0, s_axis_tdata[VALUE_BITS-1:0]} + 1'b1;
                    hi_next         = s_axis_tdata[FB +: VALUE_BITS];
                    pend_valid_next = 1'b0;
                    state_next      = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (cand_reg >= {1'b0, hi_reg})
                begin
                    // End of range: flush the held prime as the last one
                    if (!pend_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = pend_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (cand_reg < (VALUE_BITS + 1)'(prl_pkg::SMALLEST_PRIME))
                begin
                    cand_next = cand_reg + 1'b1;
                end
                else
                begin
                    dvs_next   = VALUE_BITS'(prl_pkg::SMALLEST_PRIME);
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                // No divisor below the candidate divided it
                if (dvs_reg == cand_reg[VALUE_BITS-1:0])
                begin
                    state_next = S_FOUND;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (rem_res.done)
                begin
                    if (rem_res.zero)
                    begin
                        cand_next  = cand_reg + 1'b1;
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        dvs_next   = dvs_reg + 1'b1;
                        state_next = S_TEST;
                    end
                end
            end
            S_FOUND:
            begin
                // Release the previous prime, then hold this one
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = pend_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = cand_reg[VALUE_BITS-1:0];
                    cand_next       = cand_reg + 1'b1;
                    state_next      = S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        hi_reg       <= hi_next;
        dvs_reg      <= dvs_next;
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = FB'(out_data_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule
